FILE: src/ret_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and microcode for the reader epoch tracker.
// Used by the checker and all modules but ret_ram; no dependencies.
package ret_pkg;

    // Table size and derived widths
    localparam int MAX_READERS = 16;
    localparam int SLOT_W      = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int CNT_W       = $clog2(MAX_READERS + 1);
    localparam int EPOCH_W     = 64;
    localparam int OP_W        = 3;
    localparam int FSLOT_W     = 8;
    localparam int UPC_W       = 4;

    localparam logic [FSLOT_W-1:0] SLOT_LIMIT = FSLOT_W'(MAX_READERS);

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_ENTER   = 3'd1;
    localparam logic [OP_W-1:0] OP_EXIT    = 3'd2;
    localparam logic [OP_W-1:0] OP_MIN     = 3'd3;
    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd4;
    localparam logic [OP_W-1:0] OP_READ    = 3'd5;

    // Microcode addresses
    localparam logic [UPC_W-1:0] UA_IDLE     = 4'd0;
    localparam logic [UPC_W-1:0] UA_ALLOC    = 4'd1;
    localparam logic [UPC_W-1:0] UA_ENTER    = 4'd2;
    localparam logic [UPC_W-1:0] UA_EXIT     = 4'd3;
    localparam logic [UPC_W-1:0] UA_MIN_INIT = 4'd4;
    localparam logic [UPC_W-1:0] UA_MIN_LOOP = 4'd5;
    localparam logic [UPC_W-1:0] UA_MIN_LAST = 4'd6;
    localparam logic [UPC_W-1:0] UA_ADVANCE  = 4'd7;
    localparam logic [UPC_W-1:0] UA_READ     = 4'd8;
    localparam logic [UPC_W-1:0] UA_NOP      = 4'd9;

    // Next-address selection
    typedef enum logic [1:0] {
        JC_JUMP     = 2'd0,
        JC_LAST     = 2'd1,
        JC_NOT_LAST = 2'd2,
        JC_DISPATCH = 2'd3
    } jc_t;

    // State update performed by a step
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_ALLOC   = 3'd1,
        ACT_ENTER   = 3'd2,
        ACT_EXIT    = 3'd3,
        ACT_ADVANCE = 3'd4
    } act_t;

    // Source of the result word
    typedef enum logic [2:0] {
        RES_ZERO   = 3'd0,
        RES_ALLOC  = 3'd1,
        RES_SLOT   = 3'd2,
        RES_MIN    = 3'd3,
        RES_GLOBAL = 3'd4
    } res_t;

    typedef struct packed {
        jc_t              jc;
        logic [UPC_W-1:0] target;
        logic             best_load;
        logic             rd_en;
        logic             cmp_en;
        logic             idx_inc;
        logic             idx_clr;
        act_t             act;
        res_t             res;
        logic             emit;
    } cw_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch_value;
        logic [FSLOT_W-1:0] assigned_slot;
        logic               slot_exhausted;
        logic               slot_ignored;
    } res_item_t;

    // Entry address of each operation's routine
    function automatic logic [UPC_W-1:0] dispatch(input logic [OP_W-1:0] op);
        logic [UPC_W-1:0] addr;
        unique case (op)
            OP_ALLOC:   addr = UA_ALLOC;
            OP_ENTER:   addr = UA_ENTER;
            OP_EXIT:    addr = UA_EXIT;
            OP_MIN:     addr = UA_MIN_INIT;
            OP_ADVANCE: addr = UA_ADVANCE;
            OP_READ:    addr = UA_READ;
            default:    addr = UA_NOP;
        endcase
        return addr;
    endfunction

    // Control store: one word per step
    function automatic cw_t ucode(input logic [UPC_W-1:0] upc);
        cw_t cw;
        cw        = '0;
        cw.jc     = JC_JUMP;
        cw.target = UA_IDLE;
        cw.act    = ACT_NONE;
        cw.res    = RES_ZERO;
        unique case (upc)
            UA_IDLE: begin
                cw.jc = JC_DISPATCH;
            end
            UA_ALLOC: begin
                cw.act  = ACT_ALLOC;
                cw.res  = RES_ALLOC;
                cw.emit = 1'b1;
            end
            UA_ENTER: begin
                cw.act  = ACT_ENTER;
                cw.res  = RES_SLOT;
                cw.emit = 1'b1;
            end
            UA_EXIT: begin
                cw.act  = ACT_EXIT;
                cw.res  = RES_SLOT;
                cw.emit = 1'b1;
            end
            UA_MIN_INIT: begin
                // seed with the global epoch, fetch entry 0
                cw.jc        = JC_LAST;
                cw.target    = UA_MIN_LAST;
                cw.best_load = 1'b1;
                cw.rd_en     = 1'b1;
                cw.idx_inc   = 1'b1;
            end
            UA_MIN_LOOP: begin
                // fold the previous entry, fetch the next
                cw.jc      = JC_NOT_LAST;
                cw.target  = UA_MIN_LOOP;
                cw.cmp_en  = 1'b1;
                cw.rd_en   = 1'b1;
                cw.idx_inc = 1'b1;
            end
            UA_MIN_LAST: begin
                cw.cmp_en  = 1'b1;
                cw.idx_clr = 1'b1;
                cw.res     = RES_MIN;
                cw.emit    = 1'b1;
            end
            UA_ADVANCE: begin
                cw.act  = ACT_ADVANCE;
                cw.res  = RES_GLOBAL;
                cw.emit = 1'b1;
            end
            UA_READ: begin
                cw.res  = RES_GLOBAL;
                cw.emit = 1'b1;
            end
            UA_NOP: begin
                cw.emit = 1'b1;
            end
            default: begin
                cw.jc = JC_JUMP;
            end
        endcase
        return cw;
    endfunction

endpackage

FILE: src/ret_req_if.sv
`timescale 1ns / 1ps
// Request channel of the reader epoch tracker: valid/ready plus payload.
// Depends on ret_pkg for field widths.
interface ret_req_if;
    import ret_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [FSLOT_W-1:0]  slot;

    modport source (output valid, output operation, output slot, input ready);
    modport sink   (input valid, input operation, input slot, output ready);
endinterface

FILE: src/ret_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the reader epoch tracker: valid/ready plus payload.
// Depends on ret_pkg for field widths.
interface ret_rsp_if;
    import ret_pkg::*;

    logic                valid;
    logic                ready;
    logic [EPOCH_W-1:0]  epoch_value;
    logic [FSLOT_W-1:0]  assigned_slot;
    logic                slot_exhausted;
    logic                slot_ignored;

    modport source (output valid, output epoch_value, output assigned_slot,
                    output slot_exhausted, output slot_ignored, input ready);
    modport sink   (input valid, input epoch_value, input assigned_slot,
                    input slot_exhausted, input slot_ignored, output ready);
endinterface

FILE: src/ret_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ret_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ret_useq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on ret_pkg for the control word, dispatch table and microcode.
module ret_useq import ret_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic [OP_W-1:0] operation,
    input  logic            idx_last,
    input  logic            stall,
    output cw_t             cw,
    output logic            idle
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic [UPC_W-1:0] upc_inc;

    // Look up the current step
    assign cw      = ucode(upc_reg);
    assign idle    = (upc_reg == UA_IDLE);
    assign upc_inc = upc_reg + UPC_W'(1);

    // Pick the next step; hold while the result word cannot be placed
    always_comb
    begin
        upc_next = upc_reg;
        if (!stall)
        begin
            unique case (cw.jc)
                JC_JUMP:     upc_next = cw.target;
                JC_LAST:     upc_next = idx_last ? cw.target : upc_inc;
                JC_NOT_LAST: upc_next = idx_last ? upc_inc : cw.target;
                JC_DISPATCH: upc_next = req_valid ? dispatch(operation) : upc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

FILE: src/ret_dpath.sv
`timescale 1ns / 1ps
// Datapath: global epoch, allocation counter, reader table with valid bits,
// scan index and running minimum. Depends on ret_pkg and ret_ram.
module ret_dpath import ret_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  cw_t                cw,
    input  logic               go,
    input  logic [FSLOT_W-1:0] slot,
    output logic               idx_last,
    output res_item_t          result
);

    logic [EPOCH_W-1:0]     global_reg;
    logic [EPOCH_W-1:0]     global_next;
    logic [CNT_W-1:0]       nfs_reg;
    logic [CNT_W-1:0]       nfs_next;
    logic [MAX_READERS-1:0] valid_reg;
    logic [MAX_READERS-1:0] valid_next;
    logic [SLOT_W-1:0]      idx_reg;
    logic [SLOT_W-1:0]      idx_next;
    logic [EPOCH_W-1:0]     best_reg;
    logic [EPOCH_W-1:0]     best_next;
    logic                   rd_valid_reg;
    logic                   rd_valid_next;
    logic [EPOCH_W-1:0]     best_cand;
    logic [EPOCH_W-1:0]     rd_data;
    logic                   slot_ok;
    logic                   full;
    logic [SLOT_W-1:0]      slot_idx;
    logic [SLOT_W-1:0]      nfs_idx;
    logic                   ram_we;
    logic                   ram_re;

    assign slot_ok  = (slot < SLOT_LIMIT);
    assign full     = (nfs_reg == CNT_W'(MAX_READERS));
    assign slot_idx = slot[SLOT_W-1:0];
    assign nfs_idx  = nfs_reg[SLOT_W-1:0];
    assign idx_last = (idx_reg == SLOT_W'(MAX_READERS - 1));
    assign ram_we   = go && (cw.act == ACT_ENTER) && slot_ok;
    assign ram_re   = go && cw.rd_en;

    // Reader epochs; an entry without its valid bit reads as idle
    ret_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (MAX_READERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_idx),
        .wdata (global_reg),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // Fold the fetched entry into the running minimum
    assign best_cand = (rd_valid_reg && (rd_data != '0) && (rd_data < best_reg))
                       ? rd_data : best_reg;

    // State updates of the current step
    always_comb
    begin
        global_next   = global_reg;
        nfs_next      = nfs_reg;
        valid_next    = valid_reg;
        idx_next      = idx_reg;
        best_next     = best_reg;
        rd_valid_next = rd_valid_reg;
        if (go)
        begin
            unique case (cw.act)
                ACT_ALLOC:
                begin
                    if (!full)
                    begin
                        valid_next[nfs_idx] = 1'b0;
                        nfs_next            = nfs_reg + CNT_W'(1);
                    end
                end
                ACT_ENTER:
                begin
                    if (slot_ok)
                    begin
                        valid_next[slot_idx] = 1'b1;
                    end
                end
                ACT_EXIT:
                begin
                    if (slot_ok)
                    begin
                        valid_next[slot_idx] = 1'b0;
                    end
                end
                ACT_ADVANCE: global_next = global_reg + EPOCH_W'(1);
                default:     global_next = global_reg;
            endcase
            if (cw.rd_en)
            begin
                rd_valid_next = valid_reg[idx_reg];
            end
            priority if (cw.idx_clr)
            begin
                idx_next = '0;
            end
            else if (cw.idx_inc)
            begin
                idx_next = idx_reg + SLOT_W'(1);
            end
            else
            begin
                idx_next = idx_reg;
            end
            priority if (cw.best_load)
            begin
                best_next = global_reg;
            end
            else if (cw.cmp_en)
            begin
                best_next = best_cand;
            end
            else
            begin
                best_next = best_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_reg   <= EPOCH_W'(1);
            nfs_reg      <= '0;
            valid_reg    <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            global_reg   <= global_next;
            nfs_reg      <= nfs_next;
            valid_reg    <= valid_next;
            idx_reg      <= idx_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Running minimum is payload
    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    // Shape the result word
    always_comb
    begin
        result = '0;
        unique case (cw.res)
            RES_ZERO:
            begin
                result = '0;
            end
            RES_ALLOC:
            begin
                result.assigned_slot  = FSLOT_W'(nfs_reg);
                result.slot_exhausted = full;
            end
            RES_SLOT:
            begin
                result.slot_ignored = !slot_ok;
            end
            RES_MIN:
            begin
                result.epoch_value = best_cand;
            end
            RES_GLOBAL:
            begin
                result.epoch_value = global_next;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

FILE: src/reader_epoch_tracker.sv
`timescale 1ns / 1ps
// Reader epoch tracker: epoch-based reclamation reader table.
// Requests arrive on req (operation, slot); one word per request leaves on rsp
// (epoch_value, assigned_slot, slot_exhausted, slot_ignored).
// A microcoded sequencer steps a small datapath; the table sits in a RAM.
// Allocate, enter, exit, advance, read global and unused codes give their
// word in one execute step after the idle step that accepts them.
// The minimum query scans the table through the single RAM read port, one
// entry a cycle, from an init step through loop steps to a final step.
// A request is not taken before the previous one has run its last step.
// req.ready is high while the sequencer waits at its idle step; a request can
// be taken while the previous word still sits in the output register.
// If rsp is stalled, the next request runs up to its final step and holds
// there, with no state change, until the output register frees.
// Reset: global epoch 1, allocation count 0, every table entry idle through
// valid bits cleared at once, so no clearing pass is needed.
// Depends on ret_pkg, ret_req_if, ret_rsp_if, ret_useq, ret_dpath, ret_ram.
module reader_epoch_tracker import ret_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    ret_req_if.sink   req,
    ret_rsp_if.source rsp
);

    cw_t                cw;
    logic               idle;
    logic               idx_last;
    logic               stall;
    logic               go;
    logic               req_fire;
    logic [FSLOT_W-1:0] slot_reg;
    res_item_t          result;
    res_item_t          out_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    assign req.ready = idle;
    assign req_fire  = req.valid && idle;
    assign stall     = cw.emit && out_valid_reg && !rsp.ready;
    assign go        = !stall;

    ret_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .operation (req.operation),
        .idx_last  (idx_last),
        .stall     (stall),
        .cw        (cw),
        .idle      (idle)
    );

    ret_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cw       (cw),
        .go       (go),
        .slot     (slot_reg),
        .idx_last (idx_last),
        .result   (result)
    );

    // Hold the slot of the accepted request
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            slot_reg <= req.slot;
        end
    end

    // Output register: load on emit, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cw.emit && go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.emit && go)
        begin
            out_reg <= result;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.epoch_value    = out_reg.epoch_value;
    assign rsp.assigned_slot  = out_reg.assigned_slot;
    assign rsp.slot_exhausted = out_reg.slot_exhausted;
    assign rsp.slot_ignored   = out_reg.slot_ignored;

endmodule

FILE: src/ret_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the reader epoch tracker, bound to the top level.
// Depends on ret_pkg and reader_epoch_tracker.
module ret_checker import ret_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [FSLOT_W-1:0] assigned_slot,
    input logic               slot_exhausted,
    input logic               slot_ignored
);

    // A stalled word stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("response word withdrawn while stalled");

    // One request at a time: no acceptance in the cycle after one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while the previous one is still running");

    // Exhaustion reports the capacity as the slot
    a_exhausted_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && slot_exhausted) |-> (assigned_slot == SLOT_LIMIT))
        else $error("exhausted allocate did not report capacity");

    // Granted slots stay within capacity, and flags never combine
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!(slot_exhausted && slot_ignored)
                       && (assigned_slot <= SLOT_LIMIT)))
        else $error("inconsistent response flags");

endmodule

bind reader_epoch_tracker ret_checker u_ret_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .assigned_slot  (rsp.assigned_slot),
    .slot_exhausted (rsp.slot_exhausted),
    .slot_ignored   (rsp.slot_ignored)
);
